/* design/tpz_pkg.sv */
// ----------------------------------------------------------------------------
// Touch zone hit test - shared package
// Command layout, action/status/register codes and fixed sizes of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpz_pkg;

  // Fixed sizes
  localparam int unsigned CoordW      = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned ResultLimit = 8;
  localparam int unsigned CntW        = $clog2(ResultLimit);
  localparam int unsigned QueueDepth  = 2;

  // Mask that pulls the low nibble out of a raw touch byte
  localparam logic [7:0] NibbleMask = 8'h0F;

  // Action codes of an input item
  localparam logic [1:0] ACT_REPORT     = 2'd0;
  localparam logic [1:0] ACT_REGISTER   = 2'd1;
  localparam logic [1:0] ACT_UNREGISTER = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SWAP_AXES    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIRROR_X     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIRROR_Y     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PANEL_WIDTH  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PANEL_HEIGHT = 3'd4;

  // Classified command passed from front to back through the queue
  typedef struct packed {
    logic [1:0]        kind;
    logic              touched;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] cx_a;
    logic [CoordW-1:0] cy_a;
    logic [CoordW-1:0] cx_b;
    logic [CoordW-1:0] cy_b;
    logic [3:0]        slot;
  } cmd_t;

endpackage

`default_nettype wire

/* design/tpz_if.sv */
// ----------------------------------------------------------------------------
// Touch zone hit test - channel interfaces
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpz_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  status_byte;
  logic [7:0]  x_high_byte;
  logic [7:0]  x_low_byte;
  logic [7:0]  y_high_byte;
  logic [7:0]  y_low_byte;
  logic [15:0] corner_x_a;
  logic [15:0] corner_y_a;
  logic [15:0] corner_x_b;
  logic [15:0] corner_y_b;
  logic [3:0]  slot_to_free;

  modport source (
    output valid, action, status_byte, x_high_byte, x_low_byte, y_high_byte,
           y_low_byte, corner_x_a, corner_y_a, corner_x_b, corner_y_b, slot_to_free,
    input  ready
  );
  modport sink (
    input  valid, action, status_byte, x_high_byte, x_low_byte, y_high_byte,
           y_low_byte, corner_x_a, corner_y_a, corner_x_b, corner_y_b, slot_to_free,
    output ready
  );
endinterface

interface tpz_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        touched;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic        zone_hit;
  logic [3:0]  zone_slot;
  logic        last;

  modport source (
    output valid, status, touched, pos_x, pos_y, zone_hit, zone_slot, last,
    input  ready
  );
  modport sink (
    input  valid, status, touched, pos_x, pos_y, zone_hit, zone_slot, last,
    output ready
  );
endinterface

`default_nettype wire

/* design/touch_point_zone_hit_test_core.sv */
// Order: an accepted item is stored in the queue before it can be popped; its result
//   is loaded into the output register at the pop, or after the S_SCAN zone scan.
// Pacing: register, unregister and non-press reports go back to back while results are
//   taken; a press-edge report stalls pops for a slot-by-slot scan and one result
//   per hit (up to 8), set by the single-slot containment unit in the back end.
// Reset: clears configuration, zone use flags, press flag, queue and output register.
// ----------------------------------------------------------------------------
// Touch zone hit test - top level
// Front end decodes items into a short queue; back end executes them against
// the zone table and emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_point_zone_hit_test_core #(
  parameter int unsigned ZONES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tpz_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpz_pkg::CfgDataW-1:0] cfg_wdata_i,
  tpz_in_if.sink                       req_i,
  tpz_out_if.source                    rsp_o
);
  import tpz_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  tpz_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  tpz_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tpz_back #(
    .ZONES (ZONES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .rsp_o       (rsp_o)
  );

  // A zone hit is always a touched, successful report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.zone_hit |-> rsp_o.touched && (rsp_o.status == ST_OK))
    else $error("zone hit on a result that is not a touched report");

  // No touch means no coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.touched |-> (rsp_o.pos_x == '0) && (rsp_o.pos_y == '0))
    else $error("coordinates set on an untouched result");

  // Error results are single table results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_OK) |->
      !rsp_o.touched && !rsp_o.zone_hit && rsp_o.last)
    else $error("error status on a report or non-final result");

endmodule

`default_nettype wire

/* design/tpz_fifo.sv */
// ----------------------------------------------------------------------------
// Touch zone hit test - command queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tpz_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tpz_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tpz_pkg::cmd_t pop_data_o
);
  import tpz_pkg::*;

  localparam int unsigned PtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  cmd_t              entry_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CountW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store pushed item
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* design/tpz_front.sv */
// ----------------------------------------------------------------------------
// Touch zone hit test - front end
// Holds the panel configuration, accepts items, decodes touch reports into
// mapped coordinates and pushes classified commands into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tpz_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tpz_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tpz_pkg::CfgDataW-1:0]    cfg_wdata_i,
  tpz_in_if.sink                          req_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output tpz_pkg::cmd_t                   push_data_o
);
  import tpz_pkg::*;

  logic                swap_axes_q, mirror_x_q, mirror_y_q;
  logic [CfgDataW-1:0] panel_width_q, panel_height_q;

  logic              touched, action_known;
  logic [CoordW-1:0] raw_x, raw_y, sw_x, sw_y, map_x, map_y;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_axes_q    <= 1'b0;
      mirror_x_q     <= 1'b0;
      mirror_y_q     <= 1'b0;
      panel_width_q  <= '0;
      panel_height_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SWAP_AXES:    swap_axes_q    <= cfg_wdata_i[0];
        CFG_MIRROR_X:     mirror_x_q     <= cfg_wdata_i[0];
        CFG_MIRROR_Y:     mirror_y_q     <= cfg_wdata_i[0];
        CFG_PANEL_WIDTH:  panel_width_q  <= cfg_wdata_i;
        CFG_PANEL_HEIGHT: panel_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Decode touch count and raw 12-bit coordinates
  assign touched = ((req_i.status_byte & NibbleMask) != 8'h00);
  assign raw_x   = {req_i.x_high_byte & NibbleMask, req_i.x_low_byte};
  assign raw_y   = {req_i.y_high_byte & NibbleMask, req_i.y_low_byte};

  // Swap, then mirror with 16-bit wrap
  always_comb begin
    sw_x  = swap_axes_q ? raw_y : raw_x;
    sw_y  = swap_axes_q ? raw_x : raw_y;
    map_x = sw_x;
    map_y = sw_y;
    if (mirror_x_q && (panel_width_q != '0)) begin
      map_x = CoordW'(panel_width_q) - CoordW'(1) - sw_x;
    end
    if (mirror_y_q && (panel_height_q != '0)) begin
      map_y = CoordW'(panel_height_q) - CoordW'(1) - sw_y;
    end
    if (!touched) begin
      map_x = '0;
      map_y = '0;
    end
  end

  // Drop items with an unknown action; queue the rest
  assign action_known = (req_i.action == ACT_REPORT) || (req_i.action == ACT_REGISTER) ||
                        (req_i.action == ACT_UNREGISTER);
  assign push_valid_o = req_i.valid && action_known;
  assign req_i.ready  = push_ready_i;

  always_comb begin
    push_data_o.kind    = req_i.action;
    push_data_o.touched = touched;
    push_data_o.pos_x   = map_x;
    push_data_o.pos_y   = map_y;
    push_data_o.cx_a    = req_i.corner_x_a;
    push_data_o.cy_a    = req_i.corner_y_a;
    push_data_o.cx_b    = req_i.corner_x_b;
    push_data_o.cy_b    = req_i.corner_y_b;
    push_data_o.slot    = req_i.slot_to_free;
  end

endmodule

`default_nettype wire

/* design/tpz_back.sv */
// ----------------------------------------------------------------------------
// Touch zone hit test - back end
// Owns the zone table and press flag, executes queued commands, scans the
// zones one slot per cycle on a press edge and emits results through an
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpz_back #(
  parameter int unsigned ZONES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  tpz_pkg::cmd_t pop_data_i,
  tpz_out_if.source     rsp_o
);
  import tpz_pkg::*;

  localparam int unsigned SlotW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int unsigned SlotCmpW = 5;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_e;

  typedef struct packed {
    logic [1:0]        status;
    logic              touched;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic              zone_hit;
    logic [3:0]        zone_slot;
    logic              last;
  } rsp_t;

  state_e            state_q;
  logic [ZONES-1:0]  in_use_q;
  logic              was_pressed_q;
  logic [SlotW-1:0]  idx_q;
  logic [ZONES-1:0]  mask_q;
  logic [CntW-1:0]   cnt_q;
  logic [CoordW-1:0] cur_x_q, cur_y_q;
  logic              out_valid_q;
  rsp_t              out_q;

  logic [CoordW-1:0] left_q [ZONES];
  logic [CoordW-1:0] right_q [ZONES];
  logic [CoordW-1:0] top_q [ZONES];
  logic [CoordW-1:0] bottom_q [ZONES];

  logic              can_load, take, tbl_we, slot_ok, scan_hit, emit_last;
  logic              free_found, press_edge, out_load;
  logic [SlotW-1:0]  free_slot, hit_slot;
  logic [ZONES-1:0]  mask_next;
  logic [CoordW-1:0] lo_x, hi_x, lo_y, hi_y;

  // Handshakes
  assign can_load    = !out_valid_q || rsp_o.ready;
  assign pop_ready_o = (state_q == S_IDLE) && can_load;
  assign take        = pop_valid_i && pop_ready_o;

  // A report that starts a press goes to the slot scan instead of the output
  assign press_edge = (pop_data_i.kind == ACT_REPORT) && pop_data_i.touched && !was_pressed_q;
  assign out_load   = (take && !press_edge) || ((state_q == S_EMIT) && can_load);

  // Lowest free slot and lowest pending hit
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    hit_slot   = '0;
    for (int i = ZONES - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_slot  = SlotW'(i);
      end
      if (mask_q[i]) begin
        hit_slot = SlotW'(i);
      end
    end
  end

  // Clear lowest pending hit; stop at the result limit
  assign mask_next = mask_q & (mask_q - ZONES'(1));
  assign emit_last = (mask_next == '0) || (cnt_q == CntW'(ResultLimit - 1));

  // Order corners at registration
  assign lo_x = (pop_data_i.cx_a > pop_data_i.cx_b) ? pop_data_i.cx_b : pop_data_i.cx_a;
  assign hi_x = (pop_data_i.cx_a > pop_data_i.cx_b) ? pop_data_i.cx_a : pop_data_i.cx_b;
  assign lo_y = (pop_data_i.cy_a > pop_data_i.cy_b) ? pop_data_i.cy_b : pop_data_i.cy_a;
  assign hi_y = (pop_data_i.cy_a > pop_data_i.cy_b) ? pop_data_i.cy_a : pop_data_i.cy_b;

  assign tbl_we  = take && (pop_data_i.kind == ACT_REGISTER) && free_found;
  assign slot_ok = ({1'b0, pop_data_i.slot} < SlotCmpW'(ZONES));

  // Containment test of the slot under scan
  assign scan_hit = in_use_q[idx_q] &&
                    (cur_x_q >= left_q[idx_q]) && (cur_x_q <= right_q[idx_q]) &&
                    (cur_y_q >= top_q[idx_q]) && (cur_y_q <= bottom_q[idx_q]);

  // Zone rectangles
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      left_q[free_slot]   <= lo_x;
      right_q[free_slot]  <= hi_x;
      top_q[free_slot]    <= lo_y;
      bottom_q[free_slot] <= hi_y;
    end
  end

  // Sequencer, table flags and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      in_use_q      <= '0;
      was_pressed_q <= 1'b0;
      idx_q         <= '0;
      mask_q        <= '0;
      cnt_q         <= '0;
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      // Hold a waiting result until taken; raise valid on every load
      out_valid_q <= out_load || (out_valid_q && !rsp_o.ready);
      case (state_q)
        S_IDLE: begin
          if (take) begin
            case (pop_data_i.kind)
              ACT_REPORT: begin
                was_pressed_q <= pop_data_i.touched;
                if (press_edge) begin
                  cur_x_q <= pop_data_i.pos_x;
                  cur_y_q <= pop_data_i.pos_y;
                  idx_q   <= '0;
                  mask_q  <= '0;
                  state_q <= S_SCAN;
                end else begin
                  out_q <= '{status: ST_OK, touched: pop_data_i.touched,
                             pos_x: pop_data_i.pos_x, pos_y: pop_data_i.pos_y,
                             zone_hit: 1'b0, zone_slot: 4'd0, last: 1'b1};
                end
              end
              ACT_REGISTER: begin
                if (free_found) begin
                  in_use_q[free_slot] <= 1'b1;
                  out_q <= '{status: ST_OK, touched: 1'b0, pos_x: '0, pos_y: '0,
                             zone_hit: 1'b0, zone_slot: 4'(free_slot), last: 1'b1};
                end else begin
                  out_q <= '{status: ST_FULL, touched: 1'b0, pos_x: '0, pos_y: '0,
                             zone_hit: 1'b0, zone_slot: 4'd0, last: 1'b1};
                end
              end
              ACT_UNREGISTER: begin
                if (slot_ok) begin
                  in_use_q[pop_data_i.slot[SlotW-1:0]] <= 1'b0;
                end
                out_q <= '{status: slot_ok ? ST_OK : ST_BAD_SLOT, touched: 1'b0,
                           pos_x: '0, pos_y: '0, zone_hit: 1'b0,
                           zone_slot: pop_data_i.slot, last: 1'b1};
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          mask_q[idx_q] <= scan_hit;
          if (idx_q == SlotW'(ZONES - 1)) begin
            cnt_q   <= '0;
            state_q <= S_EMIT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (can_load) begin
            if (mask_q == '0) begin
              out_q <= '{status: ST_OK, touched: 1'b1, pos_x: cur_x_q, pos_y: cur_y_q,
                         zone_hit: 1'b0, zone_slot: 4'd0, last: 1'b1};
              state_q <= S_IDLE;
            end else begin
              out_q <= '{status: ST_OK, touched: 1'b1, pos_x: cur_x_q, pos_y: cur_y_q,
                         zone_hit: 1'b1, zone_slot: 4'(hit_slot), last: emit_last};
              mask_q <= mask_next;
              cnt_q  <= cnt_q + 1'b1;
              if (emit_last) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Drive result channel
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_q.status;
  assign rsp_o.touched   = out_q.touched;
  assign rsp_o.pos_x     = out_q.pos_x;
  assign rsp_o.pos_y     = out_q.pos_y;
  assign rsp_o.zone_hit  = out_q.zone_hit;
  assign rsp_o.zone_slot = out_q.zone_slot;
  assign rsp_o.last      = out_q.last;

endmodule

`default_nettype wire

/* tb/sv/tpz_hit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch zone hit test - result checker
// Watches the configuration port and both channels, keeps its own zone table,
// press flag and mapping settings, predicts the results of every accepted item
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------

module tpz_hit_checker #(
  parameter int unsigned ZONES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tpz_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpz_pkg::CfgDataW-1:0] cfg_wdata_i,
  tpz_in_if                            req_i,
  tpz_out_if                           rsp_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_count_o
);

  import tpz_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic        touched;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        zone_hit;
    logic [3:0]  zone_slot;
    logic        last;
  } hit_result_t;

  // Mapping settings as written through the configuration port
  logic                swap_xy;
  logic                flip_x;
  logic                flip_y;
  logic [CfgDataW-1:0] width_px;
  logic [CfgDataW-1:0] height_px;

  // Zone table and press flag
  logic        zone_used [ZONES];
  logic [15:0] corner_xa [ZONES];
  logic [15:0] corner_ya [ZONES];
  logic [15:0] corner_xb [ZONES];
  logic [15:0] corner_yb [ZONES];
  logic        pressed_before;

  hit_result_t zone_results_due [$];
  int unsigned fails;

  function automatic hit_result_t make_result(logic [1:0] st, logic tch, logic [15:0] x,
                                              logic [15:0] y, logic hit, logic [3:0] slot,
                                              logic fin);
    hit_result_t r;
    r.status    = st;
    r.touched   = tch;
    r.pos_x     = x;
    r.pos_y     = y;
    r.zone_hit  = hit;
    r.zone_slot = slot;
    r.last      = fin;
    return r;
  endfunction

  function automatic string describe(hit_result_t r);
    return $sformatf("status=%0d touched=%0d x=%0d y=%0d hit=%0d slot=%0d last=%0d",
                     r.status, r.touched, r.pos_x, r.pos_y, r.zone_hit, r.zone_slot, r.last);
  endfunction

  // Corners may come in either order: sort them before the bounds test
  function automatic logic zone_holds(int unsigned s, logic [15:0] x, logic [15:0] y);
    logic [15:0] lo_x, hi_x, lo_y, hi_y;
    lo_x = (corner_xa[s] < corner_xb[s]) ? corner_xa[s] : corner_xb[s];
    hi_x = (corner_xa[s] < corner_xb[s]) ? corner_xb[s] : corner_xa[s];
    lo_y = (corner_ya[s] < corner_yb[s]) ? corner_ya[s] : corner_yb[s];
    hi_y = (corner_ya[s] < corner_yb[s]) ? corner_yb[s] : corner_ya[s];
    return (x >= lo_x) && (x <= hi_x) && (y >= lo_y) && (y <= hi_y);
  endfunction

  task automatic predict_hit_test();
    logic        tch;
    logic        found;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] tmp;
    int unsigned hits;
    hit_result_t r;
    case (req_i.action)
      ACT_REPORT: begin
        tch  = (req_i.status_byte & NibbleMask) != 8'h00;
        px   = 16'h0000;
        py   = 16'h0000;
        hits = 0;
        // Decode the 12-bit point, then swap and mirror mod 2^16
        if (tch) begin
          px = {req_i.x_high_byte & NibbleMask, req_i.x_low_byte};
          py = {req_i.y_high_byte & NibbleMask, req_i.y_low_byte};
          if (swap_xy) begin
            tmp = px;
            px  = py;
            py  = tmp;
          end
          if (flip_x && width_px != '0) px = 16'(width_px) - 16'd1 - px;
          if (flip_y && height_px != '0) py = 16'(height_px) - 16'd1 - py;
        end
        // Scan the zones on a press edge only, lowest slot first
        if (tch && !pressed_before) begin
          for (int unsigned s = 0; s < ZONES; s++) begin
            if (zone_used[s] && hits < ResultLimit && zone_holds(s, px, py)) begin
              zone_results_due.push_back(make_result(ST_OK, 1'b1, px, py, 1'b1, 4'(s), 1'b0));
              hits++;
            end
          end
        end
        pressed_before = tch;
        if (hits == 0) begin
          zone_results_due.push_back(make_result(ST_OK, tch, px, py, 1'b0, 4'd0, 1'b1));
        end else begin
          r = zone_results_due.pop_back();
          r.last = 1'b1;
          zone_results_due.push_back(r);
        end
      end
      ACT_REGISTER: begin
        found = 1'b0;
        for (int unsigned s = 0; s < ZONES; s++) begin
          if (!found && !zone_used[s]) begin
            found        = 1'b1;
            zone_used[s] = 1'b1;
            corner_xa[s] = req_i.corner_x_a;
            corner_ya[s] = req_i.corner_y_a;
            corner_xb[s] = req_i.corner_x_b;
            corner_yb[s] = req_i.corner_y_b;
            zone_results_due.push_back(make_result(ST_OK, 1'b0, '0, '0, 1'b0, 4'(s), 1'b1));
          end
        end
        if (!found) begin
          zone_results_due.push_back(make_result(ST_FULL, 1'b0, '0, '0, 1'b0, 4'd0, 1'b1));
        end
      end
      ACT_UNREGISTER: begin
        if (req_i.slot_to_free >= ZONES) begin
          zone_results_due.push_back(make_result(ST_BAD_SLOT, 1'b0, '0, '0, 1'b0,
                                                 req_i.slot_to_free, 1'b1));
        end else begin
          zone_used[req_i.slot_to_free] = 1'b0;
          zone_results_due.push_back(make_result(ST_OK, 1'b0, '0, '0, 1'b0,
                                                 req_i.slot_to_free, 1'b1));
        end
      end
      // Any other action leaves the state alone and gives nothing
      default: ;
    endcase
  endtask

  task automatic check_result();
    hit_result_t seen;
    hit_result_t want;
    seen = make_result(rsp_i.status, rsp_i.touched, rsp_i.pos_x, rsp_i.pos_y,
                       rsp_i.zone_hit, rsp_i.zone_slot, rsp_i.last);
    if (zone_results_due.size() == 0) begin
      fails++;
      $display("%0t: result with nothing expected, actual %s", $time, describe(seen));
    end else begin
      want = zone_results_due.pop_front();
      if (seen !== want) begin
        fails++;
        $display("%0t: result mismatch, expected %s, actual %s", $time, describe(want),
                 describe(seen));
      end
    end
  endtask

  // Track configuration, predict on accepted items, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_xy        = 1'b0;
      flip_x         = 1'b0;
      flip_y         = 1'b0;
      width_px       = '0;
      height_px      = '0;
      pressed_before = 1'b0;
      for (int unsigned s = 0; s < ZONES; s++) zone_used[s] = 1'b0;
      zone_results_due.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SWAP_AXES:    swap_xy   = cfg_wdata_i[0];
          CFG_MIRROR_X:     flip_x    = cfg_wdata_i[0];
          CFG_MIRROR_Y:     flip_y    = cfg_wdata_i[0];
          CFG_PANEL_WIDTH:  width_px  = cfg_wdata_i;
          CFG_PANEL_HEIGHT: height_px = cfg_wdata_i;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) predict_hit_test();
      if (rsp_i.valid && rsp_i.ready) check_result();
    end
    fail_count_o    <= fails;
    pending_count_o <= zone_results_due.size();
  end

endmodule

/* tb/sv/tb_touch_point_zone_hit_test_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch zone hit test - testbench top
// Drives zone registration, zone release, raw touch reports and unknown actions
// with random gaps and result stalls across several panel mappings, and gives the
// verdict from the failure and pending counts of the checker beside the block.
// ----------------------------------------------------------------------------

module tb_touch_point_zone_hit_test_core;

  import tpz_pkg::*;

  localparam int unsigned NumZones      = 8;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles  = 24;
  localparam int unsigned WatchdogLimit = 4000;

  // No block code exists for the fourth action
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0]  action;
    logic [7:0]  status_byte;
    logic [7:0]  x_high_byte;
    logic [7:0]  x_low_byte;
    logic [7:0]  y_high_byte;
    logic [7:0]  y_low_byte;
    logic [15:0] corner_x_a;
    logic [15:0] corner_y_a;
    logic [15:0] corner_x_b;
    logic [15:0] corner_y_b;
    logic [3:0]  slot_to_free;
  } touch_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int unsigned         fail_total;
  int unsigned         pending_results;

  bit          no_idle      = 1'b0;
  int unsigned hold_off_ask = 0;
  int unsigned quiet_cycles = 0;

  tpz_in_if  req_if ();
  tpz_out_if rsp_if ();

  touch_point_zone_hit_test_core #(
    .ZONES(NumZones)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  tpz_hit_checker #(
    .ZONES(NumZones)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .fail_count_o   (fail_total),
    .pending_count_o(pending_results)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  // Fill every field at random so unused fields carry noise
  function automatic touch_item_t noise_item();
    touch_item_t it;
    it.action       = 2'($urandom_range(0, 3));
    it.status_byte  = 8'($urandom);
    it.x_high_byte  = 8'($urandom);
    it.x_low_byte   = 8'($urandom);
    it.y_high_byte  = 8'($urandom);
    it.y_low_byte   = 8'($urandom);
    it.corner_x_a   = 16'($urandom);
    it.corner_y_a   = 16'($urandom);
    it.corner_x_b   = 16'($urandom);
    it.corner_y_b   = 16'($urandom);
    it.slot_to_free = 4'($urandom);
    return it;
  endfunction

  function automatic touch_item_t report_of(logic [7:0] st, logic [7:0] xh, logic [7:0] xl,
                                            logic [7:0] yh, logic [7:0] yl);
    touch_item_t it;
    it             = noise_item();
    it.action      = ACT_REPORT;
    it.status_byte = st;
    it.x_high_byte = xh;
    it.x_low_byte  = xl;
    it.y_high_byte = yh;
    it.y_low_byte  = yl;
    return it;
  endfunction

  function automatic touch_item_t zone_of(logic [15:0] xa, logic [15:0] ya, logic [15:0] xb,
                                          logic [15:0] yb);
    touch_item_t it;
    it            = noise_item();
    it.action     = ACT_REGISTER;
    it.corner_x_a = xa;
    it.corner_y_a = ya;
    it.corner_x_b = xb;
    it.corner_y_b = yb;
    return it;
  endfunction

  function automatic touch_item_t free_of(logic [3:0] slot);
    touch_item_t it;
    it              = noise_item();
    it.action       = ACT_UNREGISTER;
    it.slot_to_free = slot;
    return it;
  endfunction

  function automatic touch_item_t random_report(bit tch);
    logic [3:0] count;
    count = tch ? 4'($urandom_range(1, 15)) : 4'h0;
    return report_of({4'($urandom), count}, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input touch_item_t it);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.action       <= it.action;
    req_if.status_byte  <= it.status_byte;
    req_if.x_high_byte  <= it.x_high_byte;
    req_if.x_low_byte   <= it.x_low_byte;
    req_if.y_high_byte  <= it.y_high_byte;
    req_if.y_low_byte   <= it.y_low_byte;
    req_if.corner_x_a   <= it.corner_x_a;
    req_if.corner_y_a   <= it.corner_y_a;
    req_if.corner_x_b   <= it.corner_x_b;
    req_if.corner_y_b   <= it.corner_y_b;
    req_if.slot_to_free <= it.slot_to_free;
    req_if.valid        <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Drop valid, wait for every result, then let items without results retire
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input bit swap, input bit mx, input bit my,
                              input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h);
    logic [CfgIdxW-1:0]  idx [5];
    logic [CfgDataW-1:0] val [5];
    idx = '{CFG_SWAP_AXES, CFG_MIRROR_X, CFG_MIRROR_Y, CFG_PANEL_WIDTH, CFG_PANEL_HEIGHT};
    val = '{CfgDataW'(swap), CfgDataW'(mx), CfgDataW'(my), w, h};
    wait_idle();
    for (int k = 0; k < 5; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Taps (a press, often after a release) as the largest share, over a churning zone table, plus noise
  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned mode;
    touch_item_t it;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if ($urandom_range(0, 2) != 0) begin
          send_item(random_report(1'b0));
          sent++;
        end
        send_item(random_report(1'b1));
        sent++;
      end else if (pick < 50) begin
        send_item(random_report(1'b0));
        sent++;
      end else if (pick < 68) begin
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
          it = zone_of(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
          if ($urandom_range(0, 1) != 0) it = zone_of(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        end else if (mode == 1) begin
          it = zone_of(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          it = zone_of(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                       16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)));
        end
        send_item(it);
        sent++;
      end else if (pick < 85) begin
        if ($urandom_range(0, 4) == 0) send_item(free_of(4'($urandom_range(8, 15))));
        else send_item(free_of(4'($urandom_range(0, 7))));
        sent++;
      end else if (pick < 90) begin
        it        = noise_item();
        it.action = ACT_UNKNOWN;
        send_item(it);
      end else begin
        send_item(random_report(1'b1));
        sent++;
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    touch_item_t it;
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_wdata           <= '0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_REPORT;
    req_if.status_byte  <= '0;
    req_if.x_high_byte  <= '0;
    req_if.x_low_byte   <= '0;
    req_if.y_high_byte  <= '0;
    req_if.y_low_byte   <= '0;
    req_if.corner_x_a   <= '0;
    req_if.corner_y_a   <= '0;
    req_if.corner_x_b   <= '0;
    req_if.corner_y_b   <= '0;
    req_if.slot_to_free <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_config(1'b0, 1'b0, 1'b0, '0, '0);

    // Empty table: release, then press with X at its top and Y at zero
    send_item(report_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(report_of(8'h01, 8'h0F, 8'hFF, 8'h00, 8'h00));
    // Fill the table with zones that all hold (200, 300), corners in both orders
    send_item(zone_of(16'd100, 16'd200, 16'd300, 16'd400));
    send_item(zone_of(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
    send_item(zone_of(16'd200, 16'd300, 16'd200, 16'd300));
    send_item(zone_of(16'd4095, 16'd4095, 16'd0, 16'd0));
    send_item(zone_of(16'd200, 16'd0, 16'd4095, 16'd300));
    send_item(zone_of(16'd0, 16'd300, 16'd200, 16'hFFFF));
    send_item(zone_of(16'd199, 16'd299, 16'd201, 16'd301));
    send_item(zone_of(16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
    // Table full
    send_item(zone_of(16'd1, 16'd2, 16'd3, 16'd4));
    // Release with upper nibbles set, then a press that hits every zone
    send_item(report_of(8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(report_of(8'hFF, 8'hF0, 8'hC8, 8'hF1, 8'h2C));
    // Held press: no edge, no scan
    send_item(report_of(8'h05, 8'h00, 8'hC8, 8'h01, 8'h2C));
    // Tap at the far corner, then just off the point zone
    send_item(report_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(report_of(8'h0F, 8'h0F, 8'hFF, 8'h0F, 8'hFF));
    send_item(report_of(8'h10, 8'h0A, 8'h55, 8'h05, 8'hAA));
    send_item(report_of(8'h01, 8'h00, 8'hC9, 8'h01, 8'h2C));
    // Free a slot twice, then bad slot indexes
    send_item(free_of(4'd3));
    send_item(free_of(4'd3));
    send_item(free_of(4'd8));
    send_item(free_of(4'd15));
    // Reuse the freed slot
    send_item(zone_of(16'd5000, 16'd5000, 16'd6000, 16'd6000));
    // Unknown action
    it        = noise_item();
    it.action = ACT_UNKNOWN;
    send_item(it);
    // Tap at the origin
    send_item(report_of(8'hA0, 8'h50, 8'h00, 8'hA0, 8'h00));
    send_item(report_of(8'h02, 8'h00, 8'h00, 8'h00, 8'h00));

    // Swap and full mirror on a 4096 by 4096 panel
    write_config(1'b1, 1'b1, 1'b1, 13'd4096, 13'd4096);
    run_phase(35);

    // One-pixel panel wraps mirrored points; stall results for a long stretch
    write_config(1'b0, 1'b1, 1'b1, 13'd1, 13'd1);
    hold_off_ask <= hold_off_ask + 1;
    run_phase(35);

    // Zero sizes disable mirroring; run back to back on both sides
    write_config(1'b1, 1'b0, 1'b1, 13'd0, 13'd0);
    no_idle <= 1'b1;
    run_phase(35);
    no_idle <= 1'b0;

    // Random settings; pause the sender until all results have come
    write_config(1'($urandom), 1'($urandom), 1'($urandom), 13'($urandom_range(0, 4096)),
                 13'($urandom_range(0, 4096)));
    run_phase(15);
    wait_idle();
    run_phase(15);

    write_config(1'($urandom), 1'($urandom), 1'($urandom), 13'($urandom_range(0, 4096)),
                 13'($urandom_range(0, 4096)));
    run_phase(35);

    wait_idle();
    if (fail_total == 0 && pending_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random stall after each result, long hold-off on request
  initial begin
    int unsigned stall;
    int unsigned hold_off_seen;
    rsp_if.ready <= 1'b0;
    stall         = 0;
    hold_off_seen = 0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) stall = draw_wait();
      if (hold_off_ask != hold_off_seen) begin
        hold_off_seen = hold_off_ask;
        stall         = HoldOffCycles;
      end
      rsp_if.ready <= (stall == 0);
      if (stall != 0) stall--;
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

/* filelist.f */
design/tpz_pkg.sv
design/tpz_if.sv
design/tpz_fifo.sv
design/tpz_front.sv
design/tpz_back.sv
design/touch_point_zone_hit_test_core.sv
tb/sv/tpz_hit_checker.sv
tb/sv/tb_touch_point_zone_hit_test_core.sv
